### rtl/rtm_pkg.sv
package rtm_pkg;

    localparam int HALF_W    = 64;
    localparam int VEC_W     = 2 * HALF_W;
    localparam int MODE_W    = 3;
    localparam int TSEL_W    = 2;
    localparam int RIDX_W    = 6;
    localparam int BIT_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 3;

    localparam int DEFAULT_RULES_PER_TABLE = 64;
    localparam int DEFAULT_ADDR_W          = $clog2(DEFAULT_RULES_PER_TABLE) + TSEL_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 3'd0,
        MODE_SET   = 3'd1,
        MODE_CLEAR = 3'd2,
        MODE_APPLY = 3'd3,
        MODE_EVAL  = 3'd4
    } mode_t;

    localparam logic [TSEL_W-1:0] TBL_PREPARE = 2'd0;
    localparam logic [TSEL_W-1:0] TBL_MAIN    = 2'd1;
    localparam logic [TSEL_W-1:0] TBL_STATIC  = 2'd2;
    localparam logic [TSEL_W-1:0] TBL_DYNAMIC = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PREPARE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HIGH     = 3'd5;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [VEC_W-1:0] cond;
        logic [VEC_W-1:0] result;
    } rule_t;

endpackage

### rtl/rtm_rule_ram.sv
module rtm_rule_ram #(
    parameter int ADDR_W = rtm_pkg::DEFAULT_ADDR_W
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  rtm_pkg::rule_t      wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output rtm_pkg::rule_t      rd_data
);
    import rtm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    rule_t rule_mem_reg [DEPTH];
    rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= rule_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/two_phase_rule_matcher.sv
// Two-phase rule matcher.
// Requests arrive on in_valid/in_stall with mode, table_select, rule_index,
// bit_index and the two 128-bit vectors; one result per request leaves on
// out_valid/out_stall. Configuration is written through cfg_write, cfg_index
// and cfg_data; the user must write it only while the block is idle, which
// the block itself does not enforce.
// Rule writes, bit set/clear and mask application update the state at the
// edge that accepts the request; the result then moves to the output register
// once that register is free, and the next request is accepted once the
// result has moved there.
// An evaluation walks the rule memory one entry per cycle through the
// prepare, main, static and dynamic tables in turn, limited by each count
// clipped to RULES_PER_TABLE, then passes through the result state to the
// output. The single read port of the rule memory sets this pace.
// After reset all 4 * 2^clog2(RULES_PER_TABLE) rule memory entries (256 by
// default) are swept to zero; in_stall stays high meanwhile.
// A result waiting behind out_stall is held, and the block takes one more
// request whose result waits inside until the output register is free.
module two_phase_rule_matcher #(
    parameter int RULES_PER_TABLE = rtm_pkg::DEFAULT_RULES_PER_TABLE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rtm_pkg::MODE_W-1:0]    mode,
    input  logic [rtm_pkg::TSEL_W-1:0]    table_select,
    input  logic [rtm_pkg::RIDX_W-1:0]    rule_index,
    input  logic [rtm_pkg::BIT_W-1:0]     bit_index,
    input  logic [rtm_pkg::HALF_W-1:0]    vec_a_low,
    input  logic [rtm_pkg::HALF_W-1:0]    vec_a_high,
    input  logic [rtm_pkg::HALF_W-1:0]    vec_b_low,
    input  logic [rtm_pkg::HALF_W-1:0]    vec_b_high,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status_changed,
    output logic                          evaluated,
    output logic                          was_dirty,
    output logic [rtm_pkg::HALF_W-1:0]    main_out_low,
    output logic [rtm_pkg::HALF_W-1:0]    main_out_high,
    output logic [rtm_pkg::HALF_W-1:0]    sense_out_low,
    output logic [rtm_pkg::HALF_W-1:0]    sense_out_high,
    input  logic                          cfg_write,
    input  logic [rtm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtm_pkg::HALF_W-1:0]    cfg_data
);
    import rtm_pkg::*;

    localparam int RW = $clog2(RULES_PER_TABLE);
    localparam int AW = RW + TSEL_W;
    localparam int LW = $clog2(RULES_PER_TABLE + 1);
    localparam int IW = (RW > RIDX_W) ? RW : RIDX_W;

    function automatic logic [LW-1:0] limit_of(input logic [COUNT_W-1:0] cnt);
        if (int'(cnt) > RULES_PER_TABLE)
        begin
            return LW'(RULES_PER_TABLE);
        end
        return LW'(cnt);
    endfunction

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  prepare_count_reg, main_count_reg;
    logic [COUNT_W-1:0]  static_count_reg, dynamic_count_reg;
    logic [HALF_W-1:0]   base_low_reg, base_high_reg;
    logic [VEC_W-1:0]    status_reg;
    logic                dirty_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [TSEL_W-1:0]   tbl_reg;
    logic [LW-1:0]       idx_reg;
    logic                rd_valid_reg;
    logic [TSEL_W-1:0]   rd_tbl_reg;
    logic [VEC_W-1:0]    pre_reg, main_reg, sense_reg;
    logic                res_changed_reg, res_eval_reg, res_dirty_reg;
    logic                out_valid_reg;
    logic                out_changed_reg, out_eval_reg, out_dirty_reg;
    logic [VEC_W-1:0]    out_main_reg, out_sense_reg;

    mode_t               mode_op;
    logic                accept;
    logic                is_eval, is_write;
    logic [VEC_W-1:0]    vec_a, vec_b, bit_mask, status_new;
    logic                changed;
    logic [LW-1:0]       lim_prepare, lim_main, lim_static, lim_dynamic;
    logic [LW-1:0]       cur_limit, wr_limit;
    logic [IW-1:0]       ridx_ext;
    logic                walk_issue, out_free;
    logic                rd_en, out_load, eval_start;
    logic                wr_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    rule_t               wr_data, rd_data;
    logic [VEC_W-1:0]    work;
    logic                fires;

    assign mode_op  = mode_t'(mode);
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign is_eval  = (mode_op == MODE_EVAL);
    assign is_write = (mode_op == MODE_WRITE);
    assign vec_a    = {vec_a_high, vec_a_low};
    assign vec_b    = {vec_b_high, vec_b_low};
    assign bit_mask = VEC_W'(1) << bit_index;

    always_comb
    begin
        status_new = status_reg;
        unique case (mode_op)
            MODE_SET:   status_new = status_reg | bit_mask;
            MODE_CLEAR: status_new = status_reg & ~bit_mask;
            MODE_APPLY: status_new = vec_a | (status_reg & vec_b);
            default:    status_new = status_reg;
        endcase
    end

    assign changed = (status_new != status_reg);

    assign lim_prepare = limit_of(prepare_count_reg);
    assign lim_main    = limit_of(main_count_reg);
    assign lim_static  = limit_of(static_count_reg);
    assign lim_dynamic = limit_of(dynamic_count_reg);

    always_comb
    begin
        unique case (tbl_reg)
            TBL_PREPARE: cur_limit = lim_prepare;
            TBL_MAIN:    cur_limit = lim_main;
            TBL_STATIC:  cur_limit = lim_static;
            default:     cur_limit = lim_dynamic;
        endcase
        unique case (table_select)
            TBL_PREPARE: wr_limit = lim_prepare;
            TBL_MAIN:    wr_limit = lim_main;
            TBL_STATIC:  wr_limit = lim_static;
            default:     wr_limit = lim_dynamic;
        endcase
    end

    assign walk_issue = (idx_reg < cur_limit);
    assign out_free   = !out_valid_reg || !out_stall;
    assign ridx_ext   = IW'(rule_index);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_eval ? ST_EVAL : ST_RESULT;
                end
            end
            ST_EVAL:
            begin
                if (!walk_issue && (tbl_reg == TBL_DYNAMIC))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        rd_en      = (state_reg == ST_EVAL) && walk_issue;
        out_load   = (state_reg == ST_RESULT) && out_free;
        eval_start = accept && is_eval;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = accept && is_write && (32'(rule_index) < 32'(wr_limit));
            wr_addr = {table_select, ridx_ext[RW-1:0]};
            wr_data = '{cond: vec_a, result: vec_b};
        end
    end

    assign rd_addr = {tbl_reg, idx_reg[RW-1:0]};

    rtm_rule_ram #(
        .ADDR_W (AW)
    ) u_rule_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Prepare rules see the bare status; the later tables see it widened by
    // the prepare results, which are complete before the first main entry
    // comes back from the memory.
    assign work  = (rd_tbl_reg == TBL_PREPARE) ? status_reg : (status_reg | pre_reg);
    assign fires = ((rd_data.cond & ~work) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            prepare_count_reg <= '0;
            main_count_reg    <= '0;
            static_count_reg  <= '0;
            dynamic_count_reg <= '0;
            base_low_reg      <= '0;
            base_high_reg     <= '0;
            status_reg        <= '0;
            dirty_reg         <= 1'b0;
            clr_addr_reg      <= '0;
            tbl_reg           <= TBL_PREPARE;
            idx_reg           <= '0;
            rd_valid_reg      <= 1'b0;
            rd_tbl_reg        <= TBL_PREPARE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_PREPARE_COUNT: prepare_count_reg <= cfg_data[COUNT_W-1:0];
                    CFG_MAIN_COUNT:    main_count_reg    <= cfg_data[COUNT_W-1:0];
                    CFG_STATIC_COUNT:  static_count_reg  <= cfg_data[COUNT_W-1:0];
                    CFG_DYNAMIC_COUNT: dynamic_count_reg <= cfg_data[COUNT_W-1:0];
                    CFG_BASE_LOW:      base_low_reg      <= cfg_data;
                    CFG_BASE_HIGH:     base_high_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                status_reg <= status_new;
                if (is_eval)
                begin
                    dirty_reg <= 1'b0;
                end
                else if (changed)
                begin
                    dirty_reg <= 1'b1;
                end
            end
            if (eval_start)
            begin
                tbl_reg <= TBL_PREPARE;
                idx_reg <= '0;
            end
            else if (state_reg == ST_EVAL)
            begin
                if (walk_issue)
                begin
                    idx_reg <= idx_reg + LW'(1);
                end
                else if (tbl_reg != TBL_DYNAMIC)
                begin
                    tbl_reg <= tbl_reg + TSEL_W'(1);
                    idx_reg <= '0;
                end
            end
            rd_valid_reg <= rd_en;
            if (rd_en)
            begin
                rd_tbl_reg <= tbl_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            pre_reg   <= '0;
            main_reg  <= '0;
            sense_reg <= {base_high_reg, base_low_reg};
        end
        else if (rd_valid_reg && fires)
        begin
            unique case (rd_tbl_reg)
                TBL_PREPARE: pre_reg   <= pre_reg | rd_data.result;
                TBL_MAIN:    main_reg  <= main_reg | rd_data.result;
                default:     sense_reg <= sense_reg | rd_data.result;
            endcase
        end
        if (accept)
        begin
            res_changed_reg <= changed;
            res_eval_reg    <= is_eval;
            res_dirty_reg   <= dirty_reg;
        end
        if (out_load)
        begin
            out_changed_reg <= res_changed_reg;
            out_eval_reg    <= res_eval_reg;
            out_dirty_reg   <= res_dirty_reg;
            out_main_reg    <= res_eval_reg ? main_reg : '0;
            out_sense_reg   <= res_eval_reg ? sense_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status_changed = out_changed_reg;
    assign evaluated      = out_eval_reg;
    assign was_dirty      = out_dirty_reg;
    assign main_out_low   = out_main_reg[HALF_W-1:0];
    assign main_out_high  = out_main_reg[VEC_W-1:HALF_W];
    assign sense_out_low  = out_sense_reg[HALF_W-1:0];
    assign sense_out_high = out_sense_reg[VEC_W-1:HALF_W];

    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_RESULT)
        else $error("result presented without passing the result state");

    a_read_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> state_reg == ST_EVAL)
        else $error("rule data returned outside the evaluation walk");

    a_vectors_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evaluated) |-> (main_out_low == '0 && main_out_high == '0
            && sense_out_low == '0 && sense_out_high == '0))
        else $error("vector fields not zero on a non-evaluation result");

    a_dirty_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_op == MODE_EVAL) |=> !dirty_reg)
        else $error("dirty flag not cleared by an evaluation request");

endmodule

### tb/sv/tb_two_phase_rule_matcher.sv
module tb_two_phase_rule_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import rtm_pkg::*;

    localparam int RULES          = DEFAULT_RULES_PER_TABLE;
    localparam int CYCLE_LIMIT    = 1_200_000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 140;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [TSEL_W-1:0] tsel;
        logic [RIDX_W-1:0] ridx;
        logic [BIT_W-1:0]  bidx;
        logic [VEC_W-1:0]  vec_a;
        logic [VEC_W-1:0]  vec_b;
    } request_t;

    typedef struct packed {
        logic             changed;
        logic             evaluated;
        logic             dirty;
        logic [VEC_W-1:0] main_vec;
        logic [VEC_W-1:0] sense_vec;
    } outcome_t;

    class rule_match_board;
        logic [VEC_W-1:0]   status;
        logic [VEC_W-1:0]   conds [4][RULES];
        logic [VEC_W-1:0]   outs [4][RULES];
        logic               dirty;
        logic [COUNT_W-1:0] counts [4];
        logic [VEC_W-1:0]   base_sense;
        outcome_t           expected_outcomes [$];
        int unsigned        mismatches;

        function new();
            status     = '0;
            dirty      = 1'b0;
            base_sense = '0;
            mismatches = 0;
            foreach (conds[t, r])
            begin
                conds[t][r] = '0;
                outs[t][r]  = '0;
            end
            foreach (counts[t])
                counts[t] = '0;
        endfunction

        function int rules_in_use(int t);
            return (counts[t] > RULES) ? RULES : int'(counts[t]);
        endfunction

        function logic [VEC_W-1:0] fired_results(int t, logic [VEC_W-1:0] work);
            logic [VEC_W-1:0] acc;
            acc = '0;
            for (int r = 0; r < rules_in_use(t); r++)
                if ((conds[t][r] & ~work) == '0)
                    acc |= outs[t][r];
            return acc;
        endfunction

        function outcome_t predict_outcome(request_t q);
            outcome_t         o;
            logic [VEC_W-1:0] old_status;
            logic [VEC_W-1:0] work;
            o          = '0;
            old_status = status;
            o.dirty    = dirty;
            case (q.op)
                MODE_WRITE:
                    if (q.ridx < rules_in_use(q.tsel))
                    begin
                        conds[q.tsel][q.ridx] = q.vec_a;
                        outs[q.tsel][q.ridx]  = q.vec_b;
                    end
                MODE_SET:   status[q.bidx] = 1'b1;
                MODE_CLEAR: status[q.bidx] = 1'b0;
                MODE_APPLY: status = q.vec_a | (status & q.vec_b);
                MODE_EVAL:
                begin
                    // The prepare results widen the vector that the other three tables see.
                    work        = status | fired_results(TBL_PREPARE, status);
                    o.main_vec  = fired_results(TBL_MAIN, work);
                    o.sense_vec = base_sense | fired_results(TBL_STATIC, work)
                                  | fired_results(TBL_DYNAMIC, work);
                    o.evaluated = 1'b1;
                    dirty       = 1'b0;
                end
                default: ;
            endcase
            if (status != old_status)
            begin
                o.changed = 1'b1;
                dirty     = 1'b1;
            end
            return o;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] value);
            case (idx)
                // The four count registers sit at the indexes of their tables.
                CFG_PREPARE_COUNT, CFG_MAIN_COUNT, CFG_STATIC_COUNT, CFG_DYNAMIC_COUNT:
                    counts[idx[1:0]] = value[COUNT_W-1:0];
                CFG_BASE_LOW:  base_sense[HALF_W-1:0]     = value;
                CFG_BASE_HIGH: base_sense[VEC_W-1:HALF_W] = value;
                default: ;
            endcase
        endfunction

        function void note_request(request_t q);
            expected_outcomes.insert(expected_outcomes.size(), predict_outcome(q));
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(outcome_t got);
            outcome_t want;
            if (expected_outcomes.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.changed !== want.changed)
                report($sformatf("status_changed %b, want %b", got.changed, want.changed));
            if (got.evaluated !== want.evaluated)
                report($sformatf("evaluated %b, want %b", got.evaluated, want.evaluated));
            if (got.dirty !== want.dirty)
                report($sformatf("was_dirty %b, want %b", got.dirty, want.dirty));
            if (got.main_vec !== want.main_vec)
                report($sformatf("main_out %h, want %h", got.main_vec, want.main_vec));
            if (got.sense_vec !== want.sense_vec)
                report($sformatf("sense_out %h, want %h", got.sense_vec, want.sense_vec));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [MODE_W-1:0]    mode;
    logic [TSEL_W-1:0]    table_select;
    logic [RIDX_W-1:0]    rule_index;
    logic [BIT_W-1:0]     bit_index;
    logic [HALF_W-1:0]    vec_a_low;
    logic [HALF_W-1:0]    vec_a_high;
    logic [HALF_W-1:0]    vec_b_low;
    logic [HALF_W-1:0]    vec_b_high;
    logic                 out_valid;
    logic                 out_stall;
    logic                 status_changed;
    logic                 evaluated;
    logic                 was_dirty;
    logic [HALF_W-1:0]    main_out_low;
    logic [HALF_W-1:0]    main_out_high;
    logic [HALF_W-1:0]    sense_out_low;
    logic [HALF_W-1:0]    sense_out_high;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0]    cfg_data;

    rule_match_board  match_board = new();
    logic [BIT_W-1:0] hot_bits [8];
    bit               hold_off_req;
    int unsigned      cycle_count;

    two_phase_rule_matcher #(
        .RULES_PER_TABLE(RULES)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .table_select   (table_select),
        .rule_index     (rule_index),
        .bit_index      (bit_index),
        .vec_a_low      (vec_a_low),
        .vec_a_high     (vec_a_high),
        .vec_b_low      (vec_b_low),
        .vec_b_high     (vec_b_high),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status_changed (status_changed),
        .evaluated      (evaluated),
        .was_dirty      (was_dirty),
        .main_out_low   (main_out_low),
        .main_out_high  (main_out_high),
        .sense_out_low  (sense_out_low),
        .sense_out_high (sense_out_high),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL two_phase_rule_matcher");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            match_board.check_result(outcome_t'({status_changed, evaluated, was_dirty,
                                                 main_out_high, main_out_low,
                                                 sense_out_high, sense_out_low}));

    // Result side: segments of differing stall patterns, plus one long hold-off on request.
    initial
    begin
        int unsigned hold_left;
        int unsigned seg_left;
        int unsigned style;
        bit          hold_done;
        out_stall = 1'b0;
        hold_left = 0;
        seg_left  = 0;
        style     = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style    = $urandom_range(0, 3);
                    seg_left = $urandom_range(16, 160);
                end
                seg_left--;
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= (seg_left % 7 < 3);
                endcase
            end
        end
    end

    function automatic logic [VEC_W-1:0] random_vec();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [BIT_W-1:0] pick_bit();
        if ($urandom_range(0, 9) < 7)
            return hot_bits[$urandom_range(0, 7)];
        return BIT_W'($urandom_range(0, VEC_W - 1));
    endfunction

    // Few bits, mostly drawn from the hot set, so that conditions actually match.
    function automatic logic [VEC_W-1:0] sparse_vec(int most);
        logic [VEC_W-1:0] v;
        v = '0;
        repeat ($urandom_range(0, most))
            v[pick_bit()] = 1'b1;
        return v;
    endfunction

    function automatic request_t make_request(logic [MODE_W-1:0] op, logic [TSEL_W-1:0] tsel,
                                              logic [RIDX_W-1:0] ridx, logic [BIT_W-1:0] bidx,
                                              logic [VEC_W-1:0] vec_a, logic [VEC_W-1:0] vec_b);
        request_t q;
        q.op    = op;
        q.tsel  = tsel;
        q.ridx  = ridx;
        q.bidx  = bidx;
        q.vec_a = vec_a;
        q.vec_b = vec_b;
        return q;
    endfunction

    function automatic request_t random_request();
        request_t q;
        int       pick;
        int       lim;
        q = make_request(MODE_EVAL, TSEL_W'($urandom), RIDX_W'($urandom), BIT_W'($urandom),
                         random_vec(), random_vec());
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            q.op = MODE_WRITE;
            lim  = match_board.rules_in_use(q.tsel);
            if (lim > 0 && $urandom_range(0, 9) < 8)
                q.ridx = RIDX_W'($urandom_range(0, lim - 1));
            case ($urandom_range(0, 9))
                0: q.vec_a = '0;
                1: ;
                default: q.vec_a = sparse_vec(3);
            endcase
            if ($urandom_range(0, 9) < 7)
                q.vec_b = sparse_vec(2);
        end
        else if (pick < 45)
        begin
            q.op   = MODE_SET;
            q.bidx = pick_bit();
        end
        else if (pick < 60)
        begin
            q.op   = MODE_CLEAR;
            q.bidx = pick_bit();
        end
        else if (pick < 68)
        begin
            q.op = MODE_APPLY;
            case ($urandom_range(0, 9))
                0: q.vec_a = '0;
                1, 2: ;
                default: q.vec_a = sparse_vec(2);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: q.vec_b = '1;
                4, 5, 6: ;
                default: q.vec_b = ~sparse_vec(3);
            endcase
        end
        else if (pick >= 93)
            q.op = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        return q;
    endfunction

    task automatic send_request(request_t q);
        mode         <= q.op;
        table_select <= q.tsel;
        rule_index   <= q.ridx;
        bit_index    <= q.bidx;
        vec_a_low    <= q.vec_a[HALF_W-1:0];
        vec_a_high   <= q.vec_a[VEC_W-1:HALF_W];
        vec_b_low    <= q.vec_b[HALF_W-1:0];
        vec_b_high   <= q.vec_b[VEC_W-1:HALF_W];
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        match_board.note_request(q);
    endtask

    task automatic pause_sender(int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (match_board.pending() != 0);
    endtask

    task automatic write_settings(int cnt_prepare, int cnt_main, int cnt_static, int cnt_dynamic,
                                  logic [VEC_W-1:0] base);
        logic [CFG_IDX_W-1:0] regs [6];
        logic [HALF_W-1:0]    values [6];
        int                   cnts [4];
        regs = '{CFG_PREPARE_COUNT, CFG_MAIN_COUNT, CFG_STATIC_COUNT, CFG_DYNAMIC_COUNT,
                 CFG_BASE_LOW, CFG_BASE_HIGH};
        cnts = '{cnt_prepare, cnt_main, cnt_static, cnt_dynamic};
        for (int i = 0; i < 4; i++)
        begin
            // Junk above the count field half of the time; only the low bits count.
            values[i] = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : '0;
            values[i][COUNT_W-1:0] = COUNT_W'(cnts[i]);
        end
        values[4] = base[HALF_W-1:0];
        values[5] = base[VEC_W-1:HALF_W];
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= values[i];
            @(posedge clk);
            match_board.set_register(regs[i], values[i]);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic run_directed();
        logic [VEC_W-1:0] one;
        one = VEC_W'(1);
        send_request(make_request(MODE_EVAL, TBL_DYNAMIC, '1, '1, '1, '1));
        send_request(make_request(MODE_SET, TBL_PREPARE, '0, BIT_W'(0), '0, '0));
        send_request(make_request(MODE_SET, TBL_PREPARE, '0, BIT_W'(127), '0, '0));
        // Setting a bit already set and clearing one already clear leave the status alone.
        send_request(make_request(MODE_SET, TBL_PREPARE, '0, BIT_W'(0), '0, '0));
        send_request(make_request(MODE_CLEAR, TBL_PREPARE, '0, BIT_W'(64), '0, '0));
        send_request(make_request(MODE_CLEAR, TBL_PREPARE, '0, BIT_W'(127), '0, '0));
        send_request(make_request(MODE_WRITE, TBL_PREPARE, RIDX_W'(0), '0, one, one << 5));
        send_request(make_request(MODE_WRITE, TBL_MAIN, '1, '0, one << 5, '1));
        send_request(make_request(MODE_WRITE, TBL_STATIC, '0, '0, one << 127, one << 100));
        send_request(make_request(MODE_WRITE, TBL_DYNAMIC, '1, '0, '1, one << 64));
        send_request(make_request(MODE_EVAL, TBL_PREPARE, '0, '0, '0, '0));
        send_request(make_request(MODE_EVAL, TBL_PREPARE, '0, '0, '0, '0));
        send_request(make_request(MODE_APPLY, TBL_PREPARE, '0, '0, '1, '0));
        send_request(make_request(MODE_EVAL, TBL_PREPARE, '0, '0, '0, '0));
        send_request(make_request(MODE_APPLY, TBL_PREPARE, '0, '0, '0, '1));
        send_request(make_request(MODE_APPLY, TBL_PREPARE, '0, '0, '0, '0));
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
            send_request(make_request(MODE_W'(m), TSEL_W'($urandom), RIDX_W'($urandom),
                                      BIT_W'($urandom), random_vec(), random_vec()));
        // An empty condition fires whatever the status holds.
        send_request(make_request(MODE_WRITE, TBL_MAIN, '0, '0, '0, '1));
        send_request(make_request(MODE_EVAL, TBL_PREPARE, '0, '0, '0, '0));
        send_request(make_request(MODE_SET, TBL_PREPARE, '0, BIT_W'(63), '0, '0));
        send_request(make_request(MODE_SET, TBL_PREPARE, '0, BIT_W'(64), '0, '0));
        send_request(make_request(MODE_EVAL, TBL_PREPARE, '0, '0, '0, '0));
    endtask

    task automatic run_bursts(int unsigned total, bit with_gaps);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < total)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < total; i++)
            begin
                send_request(random_request());
                sent++;
            end
            if (with_gaps)
                pause_sender($urandom_range(0, 6));
        end
    endtask

    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 0;
        if (roll < 30)
            return $urandom_range(RULES, (1 << COUNT_W) - 1);
        return $urandom_range(1, 12);
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_WRITE;
        table_select = TBL_PREPARE;
        rule_index   = '0;
        bit_index    = '0;
        vec_a_low    = '0;
        vec_a_high   = '0;
        vec_b_low    = '0;
        vec_b_high   = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_PREPARE_COUNT;
        cfg_data     = '0;
        hold_off_req = 1'b0;
        foreach (hot_bits[i])
            hot_bits[i] = BIT_W'(i * 17);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // The rule memory is swept clear after reset; the block stalls until done.
        do
            @(posedge clk);
        while (in_stall);

        write_settings(RULES, RULES, RULES, RULES, {64'h8000_0000_0000_0001, 64'h0});
        run_directed();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_for_results();
            case (ph)
                0: write_settings(127, 127, 127, 127, '1);
                1: write_settings(0, 0, 0, 0, random_vec());
                default: write_settings(pick_count(), pick_count(), pick_count(), pick_count(),
                                        ($urandom_range(0, 3) == 0) ? '0 : sparse_vec(4));
            endcase
            foreach (hot_bits[i])
                hot_bits[i] = BIT_W'($urandom_range(0, VEC_W - 1));
            if (ph == 2)
                hold_off_req = 1'b1;
            if (ph == 3)
            begin
                run_bursts(PHASE_REQUESTS / 2, 1'b1);
                wait_for_results();
                run_bursts(PHASE_REQUESTS / 2, 1'b1);
            end
            else
                run_bursts(PHASE_REQUESTS, ph != 1);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (match_board.mismatches == 0)
            $display("PASS two_phase_rule_matcher");
        else
            $display("FAIL two_phase_rule_matcher");
        $finish;
    end

endmodule

### filelist.f
rtl/rtm_pkg.sv
rtl/rtm_rule_ram.sv
rtl/two_phase_rule_matcher.sv
tb/sv/tb_two_phase_rule_matcher.sv
